// File: rtl/npsm_pkg.sv
// Shared types and codes for the nine-patch source mapper.
package npsm_pkg;

    localparam int COORD_WIDTH       = 16;
    localparam int SRC_W             = 12;
    localparam int CELL_REG_W        = 11;
    localparam int CLIP_FIELD_W      = 16;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int MAX_CELL_SIZE_DEF = 1024;

    localparam logic [CFG_INDEX_W-1:0] REG_DST_LEFT    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DST_TOP     = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_DST_RIGHT   = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_DST_BOTTOM  = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_WIDTH  = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_HEIGHT = CFG_INDEX_W'(5);
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_BOX    = CFG_INDEX_W'(6);
    localparam logic [CFG_INDEX_W-1:0] REG_NO_CENTRE   = CFG_INDEX_W'(7);

    localparam logic [1:0] STATUS_DRAWN        = 2'd0;
    localparam logic [1:0] STATUS_OUTSIDE_DST  = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE_CLIP = 2'd2;
    localparam logic [1:0] STATUS_CENTRE_OFF   = 2'd3;

    localparam logic [1:0] CELL_NEAR   = 2'd0;
    localparam logic [1:0] CELL_MIDDLE = 2'd1;
    localparam logic [1:0] CELL_FAR    = 2'd2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pixel_x;
        logic signed [COORD_WIDTH-1:0] pixel_y;
    } npsm_in_t;

    typedef struct packed {
        logic             drawn;
        logic [1:0]       status;
        logic [SRC_W-1:0] source_x;
        logic [SRC_W-1:0] source_y;
        logic [1:0]       patch_column;
        logic [1:0]       patch_row;
    } npsm_out_t;

endpackage

// File: rtl/nine_patch_source_mapper.sv
// Nine-patch source mapper: destination pixel to source pixel, pipelined.
//
// One pixel word is accepted per clock and one result word leaves per clock
// while m_ready is not stalling the output; a word spends 3 + ceil(16/4) = 7
// register stages in the pipe: an input register, a classify stage that splits the
// pixel into its patch cell and tests destination and clip, four remainder
// stages that each retire four dividend bits of (pixel - inner bound) mod
// cell size for both axes, and the output register. Stalls propagate back
// stage by stage, so bubbles are squeezed out and s_ready stays high while
// the pipe has room. Inner bounds and clip limits are precomputed from the
// registers in the cycle after a write; items accepted from the next cycle on
// see the new setting.
module nine_patch_source_mapper #(
    parameter int MAX_CELL_SIZE = npsm_pkg::MAX_CELL_SIZE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  npsm_pkg::npsm_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output npsm_pkg::npsm_out_t                 m_data,
    input  logic                                cfg_write,
    input  logic [npsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [npsm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import npsm_pkg::*;

    localparam int CS_W  = $clog2(MAX_CELL_SIZE + 1);
    localparam int CV_W  = (CS_W > CELL_REG_W) ? CS_W : CELL_REG_W;
    localparam int WMAX0 = (COORD_WIDTH > CS_W) ? COORD_WIDTH : CS_W;
    localparam int BW    = ((WMAX0 > SRC_W) ? WMAX0 : SRC_W) + 2;
    localparam int CMP_W = ((COORD_WIDTH > CLIP_FIELD_W) ? COORD_WIDTH : CLIP_FIELD_W) + 1;
    localparam int SPS   = 4;
    localparam int NDIV  = (COORD_WIDTH + SPS - 1) / SPS;
    localparam int DPAD  = NDIV * SPS;

    typedef struct packed {
        logic signed [BW-1:0] ilo;
        logic signed [BW-1:0] ihi;
    } bounds_t;

    typedef struct packed {
        logic [1:0]       col;
        logic [SRC_W-1:0] src;
        logic             mid;
        logic [DPAD-1:0]  quo;
    } axis_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [1:0]       col;
        logic [1:0]       row;
        logic [SRC_W-1:0] src_x;
        logic [SRC_W-1:0] src_y;
        logic             mid_x;
        logic             mid_y;
        logic [CS_W-1:0]  rem_x;
        logic [CS_W-1:0]  rem_y;
        logic [DPAD-1:0]  quo_x;
        logic [DPAD-1:0]  quo_y;
    } work_t;

    // zero reads as one, large values saturate
    function automatic logic [CS_W-1:0] clamp_cell(input logic [CELL_REG_W-1:0] v);
        logic [CV_W-1:0] vv;
        vv = CV_W'(v);
        if (vv == '0) begin
            return CS_W'(1);
        end else if (vv > CV_W'(MAX_CELL_SIZE)) begin
            return CS_W'(MAX_CELL_SIZE);
        end else begin
            return CS_W'(vv);
        end
    endfunction

    function automatic bounds_t axis_bounds(input logic signed [COORD_WIDTH-1:0] lo,
                                            input logic signed [COORD_WIDTH-1:0] hi,
                                            input logic [CS_W-1:0] cs);
        bounds_t b;
        logic signed [BW-1:0] lo_e, hi_e, cs_e, sum, mid, lo_in, hi_in;
        lo_e  = BW'(lo);
        hi_e  = BW'(hi);
        cs_e  = $signed(BW'(cs));
        sum   = lo_e + hi_e;
        // halve toward zero
        mid   = (sum + $signed(BW'(sum[BW-1]))) >>> 1;
        lo_in = lo_e + cs_e;
        hi_in = hi_e - cs_e;
        b.ilo = (lo_in < mid) ? lo_in : mid;
        b.ihi = (hi_in > mid) ? hi_in : mid;
        return b;
    endfunction

    function automatic axis_t axis_map(input logic signed [COORD_WIDTH-1:0] p,
                                       input logic signed [COORD_WIDTH-1:0] lo,
                                       input bounds_t b,
                                       input logic [CS_W-1:0] cs);
        axis_t a;
        logic signed [BW-1:0] pe, cs_e, near, far, dd;
        pe   = BW'(p);
        cs_e = $signed(BW'(cs));
        near = pe - BW'(lo);
        far  = (cs_e <<< 1) + (pe - b.ihi);
        dd   = pe - b.ilo;
        if (pe < b.ilo) begin
            a.col = CELL_NEAR;
            a.src = near[SRC_W-1:0];
            a.mid = 1'b0;
            a.quo = '0;
        end else if (pe < b.ihi) begin
            a.col = CELL_MIDDLE;
            a.src = '0;
            a.mid = 1'b1;
            a.quo = DPAD'(dd[COORD_WIDTH-1:0]);
        end else begin
            a.col = CELL_FAR;
            a.src = far[SRC_W-1:0];
            a.mid = 1'b0;
            a.quo = '0;
        end
        return a;
    endfunction

    // restoring remainder, SPS dividend bits per stage for both axes
    function automatic work_t div_step(input work_t w, input logic [CS_W-1:0] cx,
                                       input logic [CS_W-1:0] cy);
        work_t o;
        logic [CS_W:0] tx, ty;
        o = w;
        for (int j = 0; j < SPS; j++) begin
            tx = {o.rem_x, o.quo_x[DPAD-1]};
            ty = {o.rem_y, o.quo_y[DPAD-1]};
            o.quo_x = o.quo_x << 1;
            o.quo_y = o.quo_y << 1;
            if (tx >= {1'b0, cx}) begin
                tx = tx - {1'b0, cx};
            end
            if (ty >= {1'b0, cy}) begin
                ty = ty - {1'b0, cy};
            end
            o.rem_x = tx[CS_W-1:0];
            o.rem_y = ty[CS_W-1:0];
        end
        return o;
    endfunction

    // configuration registers
    logic signed [COORD_WIDTH-1:0] dst_left_reg, dst_top_reg, dst_right_reg, dst_bottom_reg;
    logic [CELL_REG_W-1:0]         cell_width_reg, cell_height_reg;
    logic [CFG_DATA_W-1:0]         clip_box_reg;
    logic                          no_centre_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dst_left_reg    <= '0;
            dst_top_reg     <= '0;
            dst_right_reg   <= '0;
            dst_bottom_reg  <= '0;
            cell_width_reg  <= CELL_REG_W'(1);
            cell_height_reg <= CELL_REG_W'(1);
            clip_box_reg    <= '0;
            no_centre_reg   <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_DST_LEFT:    dst_left_reg    <= cfg_data[COORD_WIDTH-1:0];
                REG_DST_TOP:     dst_top_reg     <= cfg_data[COORD_WIDTH-1:0];
                REG_DST_RIGHT:   dst_right_reg   <= cfg_data[COORD_WIDTH-1:0];
                REG_DST_BOTTOM:  dst_bottom_reg  <= cfg_data[COORD_WIDTH-1:0];
                REG_CELL_WIDTH:  cell_width_reg  <= cfg_data[CELL_REG_W-1:0];
                REG_CELL_HEIGHT: cell_height_reg <= cfg_data[CELL_REG_W-1:0];
                REG_CLIP_BOX:    clip_box_reg    <= cfg_data;
                REG_NO_CENTRE:   no_centre_reg   <= cfg_data[0];
                default:         no_centre_reg   <= no_centre_reg;
            endcase
        end
    end

    // values derived from the registers, updated in the cycle after the registers change
    logic [CS_W-1:0]         cw_reg, ch_reg, cw_next, ch_next;
    bounds_t                 bx_reg, by_reg, bx_next, by_next;
    logic signed [CMP_W-1:0] clip_x0_reg, clip_y0_reg, clip_x1_reg, clip_y1_reg;
    logic signed [CMP_W-1:0] clip_x0_next, clip_y0_next, clip_x1_next, clip_y1_next;
    logic                    clip_empty_reg, clip_empty_next;

    always_comb begin
        cw_next = clamp_cell(cell_width_reg);
        ch_next = clamp_cell(cell_height_reg);
        bx_next = axis_bounds(dst_left_reg, dst_right_reg, cw_next);
        by_next = axis_bounds(dst_top_reg, dst_bottom_reg, ch_next);
        clip_x0_next = CMP_W'($signed(clip_box_reg[CLIP_FIELD_W-1:0]));
        clip_y0_next = CMP_W'($signed(clip_box_reg[2*CLIP_FIELD_W-1:CLIP_FIELD_W]));
        clip_x1_next = CMP_W'($signed(clip_box_reg[3*CLIP_FIELD_W-1:2*CLIP_FIELD_W]));
        clip_y1_next = CMP_W'($signed(clip_box_reg[4*CLIP_FIELD_W-1:3*CLIP_FIELD_W]));
        clip_empty_next = (clip_x0_next >= clip_x1_next) || (clip_y0_next >= clip_y1_next);
    end

    always_ff @(posedge aclk) begin
        cw_reg         <= cw_next;
        ch_reg         <= ch_next;
        bx_reg         <= bx_next;
        by_reg         <= by_next;
        clip_x0_reg    <= clip_x0_next;
        clip_y0_reg    <= clip_y0_next;
        clip_x1_reg    <= clip_x1_next;
        clip_y1_reg    <= clip_y1_next;
        clip_empty_reg <= clip_empty_next;
    end

    // pipeline valids and stall chain
    logic      v_in_reg;
    npsm_in_t  in_reg;
    logic      v_reg    [0:NDIV];
    work_t     work_reg [0:NDIV];
    logic      en_w     [0:NDIV];
    logic      en_in, en_out;
    logic      m_valid_reg;
    npsm_out_t m_data_reg, out_next;
    work_t     work_next;

    always_comb begin
        en_out = !m_valid_reg || m_ready;
        en_w[NDIV] = !v_reg[NDIV] || en_out;
        for (int k = NDIV - 1; k >= 0; k--) begin
            en_w[k] = !v_reg[k] || en_w[k+1];
        end
        en_in = !v_in_reg || en_w[0];
    end

    assign s_ready = aresetn && en_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_in_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k <= NDIV; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else begin
            if (en_in) begin
                v_in_reg <= s_valid;
            end
            if (en_w[0]) begin
                v_reg[0] <= v_in_reg;
            end
            for (int k = 1; k <= NDIV; k++) begin
                if (en_w[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            if (en_out) begin
                m_valid_reg <= v_reg[NDIV];
            end
        end
    end

    // classify: destination, clip, cell and edge source
    always_comb begin
        axis_t ax, ay;
        logic  inside_dst, inside_clip;
        logic signed [CMP_W-1:0] pxc, pyc;
        ax = axis_map(in_reg.pixel_x, dst_left_reg, bx_reg, cw_reg);
        ay = axis_map(in_reg.pixel_y, dst_top_reg, by_reg, ch_reg);
        inside_dst = (in_reg.pixel_x >= dst_left_reg) && (in_reg.pixel_x < dst_right_reg) &&
                     (in_reg.pixel_y >= dst_top_reg) && (in_reg.pixel_y < dst_bottom_reg);
        pxc = CMP_W'(in_reg.pixel_x);
        pyc = CMP_W'(in_reg.pixel_y);
        inside_clip = (pxc >= clip_x0_reg) && (pxc < clip_x1_reg) &&
                      (pyc >= clip_y0_reg) && (pyc < clip_y1_reg);
        work_next.col   = ax.col;
        work_next.row   = ay.col;
        work_next.src_x = ax.src;
        work_next.src_y = ay.src;
        work_next.mid_x = ax.mid;
        work_next.mid_y = ay.mid;
        work_next.rem_x = '0;
        work_next.rem_y = '0;
        work_next.quo_x = ax.quo;
        work_next.quo_y = ay.quo;
        priority if (!inside_dst) begin
            work_next.status = STATUS_OUTSIDE_DST;
            work_next.col    = CELL_NEAR;
            work_next.row    = CELL_NEAR;
        end else if (!clip_empty_reg && !inside_clip) begin
            work_next.status = STATUS_OUTSIDE_CLIP;
        end else if (ax.col == CELL_MIDDLE && ay.col == CELL_MIDDLE && no_centre_reg) begin
            work_next.status = STATUS_CENTRE_OFF;
        end else begin
            work_next.status = STATUS_DRAWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_in) begin
            in_reg <= s_data;
        end
        if (en_w[0]) begin
            work_reg[0] <= work_next;
        end
        for (int k = 1; k <= NDIV; k++) begin
            if (en_w[k]) begin
                work_reg[k] <= div_step(work_reg[k-1], cw_reg, ch_reg);
            end
        end
        if (en_out) begin
            m_data_reg <= out_next;
        end
    end

    // middle cells show cell size plus remainder
    always_comb begin
        work_t         w;
        logic [CS_W:0] sum_x, sum_y;
        logic          drawn;
        w     = work_reg[NDIV];
        sum_x = {1'b0, cw_reg} + {1'b0, w.rem_x};
        sum_y = {1'b0, ch_reg} + {1'b0, w.rem_y};
        drawn = (w.status == STATUS_DRAWN);
        out_next.drawn        = drawn;
        out_next.status       = w.status;
        out_next.patch_column = w.col;
        out_next.patch_row    = w.row;
        if (!drawn) begin
            out_next.source_x = '0;
            out_next.source_y = '0;
        end else begin
            out_next.source_x = w.mid_x ? SRC_W'(sum_x) : w.src_x;
            out_next.source_y = w.mid_y ? SRC_W'(sum_y) : w.src_y;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a full input stage only happens when the whole pipe backs up from the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while output free");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.drawn == (m_data.status == STATUS_DRAWN))
        else $error("drawn flag disagrees with status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_OUTSIDE_DST |->
            m_data.patch_column == CELL_NEAR && m_data.patch_row == CELL_NEAR &&
            m_data.source_x == '0 && m_data.source_y == '0)
        else $error("pixel outside destination carries cell or source");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.patch_column != 2'd3 && m_data.patch_row != 2'd3)
        else $error("cell index out of range");

endmodule
